FILE: hw/rtl/ps2_mouse_packet_decoder_fifo_top_macros.svh
// Assertion macros shared by the PS/2 mouse decoder RTL.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef PS2_MOUSE_PACKET_DECODER_FIFO_TOP_MACROS_SVH
`define PS2_MOUSE_PACKET_DECODER_FIFO_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CHECK_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/ps2mf_pkg.sv
// Package for the PS/2 mouse packet decoder: sizes, codes, item and entry types,
// and the packet decode function. No dependencies.
package ps2mf_pkg;

    localparam int BUF_DEPTH = 16;
    localparam int BUF_IW    = $clog2(BUF_DEPTH);
    localparam int Q_DEPTH   = 4;
    localparam int Q_IW      = $clog2(Q_DEPTH);
    localparam int Q_CW      = $clog2(Q_DEPTH + 1);

    // Register index as seen on paddr[2].
    localparam logic REG_PACKET_MODE = 1'b0;

    // Header byte bit positions.
    localparam int HDR_LEFT   = 0;
    localparam int HDR_RIGHT  = 1;
    localparam int HDR_MIDDLE = 2;
    localparam int HDR_SYNC   = 3;
    localparam int HDR_XSIGN  = 4;
    localparam int HDR_YSIGN  = 5;
    localparam int HDR_XOVF   = 6;
    localparam int HDR_YOVF   = 7;

    typedef enum logic {
        CMD_BYTE = 1'b0,
        CMD_READ = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        MODE_STD   = 2'd0,
        MODE_WHEEL = 2'd1,
        MODE_BTN5  = 2'd2,
        MODE_RSVD  = 2'd3
    } mode_t;

    typedef struct packed {
        cmd_t       cmd;
        logic [7:0] data;
    } item_t;

    // Stored packet, dx in the lowest bits.
    typedef struct packed {
        logic       scroll_down;
        logic       scroll_up;
        logic       middle;
        logic       right;
        logic       left;
        logic [8:0] dy;
        logic [8:0] dx;
    } entry_t;

    function automatic logic [BUF_IW-1:0] buf_inc(input logic [BUF_IW-1:0] idx);
        logic [BUF_IW-1:0] res;
        if (idx == BUF_IW'(BUF_DEPTH - 1))
        begin
            res = '0;
        end
        else
        begin
            res = idx + 1'b1;
        end
        return res;
    endfunction

    function automatic entry_t decode_packet(input logic [7:0] hdr,
                                             input logic [7:0] xb,
                                             input logic [7:0] yb,
                                             input logic [7:0] wb,
                                             input mode_t      mode);
        entry_t e;
        // A zero magnitude stays zero even with its sign bit set.
        e.dx = {(xb != 8'd0) && hdr[HDR_XSIGN], xb};
        e.dy = {(yb != 8'd0) && hdr[HDR_YSIGN], yb};
        if (hdr[HDR_XOVF] || hdr[HDR_YOVF])
        begin
            e.dx = '0;
            e.dy = '0;
        end
        e.left        = hdr[HDR_LEFT];
        e.right       = hdr[HDR_RIGHT];
        e.middle      = hdr[HDR_MIDDLE];
        e.scroll_up   = (mode == MODE_WHEEL) && (wb != 8'd0) && wb[7];
        e.scroll_down = (mode == MODE_WHEEL) && (wb != 8'd0) && !wb[7];
        return e;
    endfunction

endpackage

FILE: hw/rtl/ps2_mouse_packet_decoder_fifo_top.sv
// Top level of the PS/2 mouse packet decoder with packet buffer.
// Holds the configuration register; depends on ps2mf_pkg, ps2mf_front,
// ps2mf_queue and ps2mf_back.
//
//  Channel   Direction  Payload
//  s_*       in         tdata = rx_byte[7:0], tuser = cmd (0 byte, 1 read)
//  m_*       out        tdata = packet_valid, delta_x, delta_y, buttons, scroll,
//                       more_pending (one item per read command)
//  APB       in/out     packet_mode at byte address 0
//
// One item is accepted per cycle when nothing stalls; a read item passes through the
// front register and a queue slot before the buffer read register loads together with
// the output valid. The packet buffer is read or written once per cycle at most. Reset
// is asynchronous and needs no clearing pass. A stalled output holds a read item at
// the head of the four-entry queue and the items behind it wait there; byte items at
// the head drain regardless of the output.
module ps2_mouse_packet_decoder_fifo_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic        s_tuser,   // [0] cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] packet_valid, [9:1] delta_x, [18:10] delta_y, [19] left_button,
    // [20] right_button, [21] middle_button, [22] scroll_up, [23] scroll_down,
    // [24] more_pending, [31:25] zero
    output logic [31:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import ps2mf_pkg::*;

    mode_t mode_reg;
    logic  cfg_we;
    logic  q_push;
    item_t q_in_item;
    logic  q_in_ready;
    logic  q_valid;
    item_t q_head;
    logic  q_pop;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready && (paddr[2] == REG_PACKET_MODE);
    assign prdata = (paddr[2] == REG_PACKET_MODE) ? {30'd0, mode_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_STD;
        end
        else if (cfg_we)
        begin
            mode_reg <= mode_t'(pwdata[1:0]);
        end
    end

    ps2mf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .q_push     (q_push),
        .q_item     (q_in_item),
        .q_in_ready (q_in_ready)
    );

    ps2mf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_item  (q_in_item),
        .in_ready   (q_in_ready),
        .head_valid (q_valid),
        .head_item  (q_head),
        .pop        (q_pop)
    );

    ps2mf_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .packet_mode (mode_reg),
        .q_valid     (q_valid),
        .q_item      (q_head),
        .q_pop       (q_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

endmodule

FILE: hw/rtl/ps2mf_front.sv
// Front stage: registers each accepted stream item, tags it as a byte or a read
// command and hands it to the queue. Depends on ps2mf_pkg.
module ps2mf_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,   // rx_byte
    input  logic             s_tuser,   // cmd
    output logic             q_push,
    output ps2mf_pkg::item_t q_item,
    input  logic             q_in_ready
);
    import ps2mf_pkg::*;

    logic  front_valid_reg;
    logic  front_valid_next;
    item_t item_reg;
    logic  accept;

    assign s_tready = !front_valid_reg || q_in_ready;
    assign accept   = s_tvalid && s_tready;
    assign q_push   = front_valid_reg;
    assign q_item   = item_reg;

    always_comb
    begin
        front_valid_next = front_valid_reg;
        if (accept)
        begin
            front_valid_next = 1'b1;
        end
        else if (q_in_ready)
        begin
            front_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_valid_reg <= 1'b0;
        end
        else
        begin
            front_valid_reg <= front_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.cmd  <= cmd_t'(s_tuser);
            item_reg.data <= s_tdata;
        end
    end

endmodule

FILE: hw/rtl/ps2mf_queue.sv
// Short item queue between the front and back stages, held in flip-flops.
// Depends on ps2mf_pkg.
module ps2mf_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  ps2mf_pkg::item_t push_item,
    output logic             in_ready,
    output logic             head_valid,
    output ps2mf_pkg::item_t head_item,
    input  logic             pop
);
    import ps2mf_pkg::*;

    item_t           slot_reg [Q_DEPTH];
    logic [Q_IW-1:0] wr_ptr_reg;
    logic [Q_IW-1:0] rd_ptr_reg;
    logic [Q_CW-1:0] count_reg;
    logic            do_push;
    logic            do_pop;

    assign in_ready   = (count_reg != Q_CW'(Q_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = slot_reg[rd_ptr_reg];
    assign do_push    = push && in_ready;
    assign do_pop     = pop && head_valid;

    function automatic logic [Q_IW-1:0] q_inc(input logic [Q_IW-1:0] p);
        logic [Q_IW-1:0] res;
        if (p == Q_IW'(Q_DEPTH - 1))
        begin
            res = '0;
        end
        else
        begin
            res = p + 1'b1;
        end
        return res;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= q_inc(wr_ptr_reg);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= q_inc(rd_ptr_reg);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

FILE: hw/rtl/ps2mf_back.sv
// Back stage: assembles mouse bytes into packets, keeps the decoded packet ring
// buffer and serves read commands into the output register.
// Depends on ps2mf_pkg and the assertion macro header.
`include "ps2_mouse_packet_decoder_fifo_top_macros.svh"

module ps2mf_back (
    input  logic             clk,
    input  logic             rst_n,
    input  ps2mf_pkg::mode_t packet_mode,
    input  logic             q_valid,
    input  ps2mf_pkg::item_t q_item,
    output logic             q_pop,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [31:0]      m_tdata
);
    import ps2mf_pkg::*;

    typedef enum logic [3:0] {
        PH_HDR = 4'b0001,
        PH_X   = 4'b0010,
        PH_Y   = 4'b0100,
        PH_W   = 4'b1000
    } phase_t;

    phase_t            phase_reg;
    phase_t            phase_next;
    logic [7:0]        hdr_reg;
    logic [7:0]        hdr_next;
    logic [7:0]        x_reg;
    logic [7:0]        x_next;
    logic [7:0]        y_reg;
    logic [7:0]        y_next;
    logic [BUF_IW-1:0] wr_idx_reg;
    logic [BUF_IW-1:0] rd_idx_reg;
    entry_t            mem [BUF_DEPTH];
    entry_t            rd_data_reg;
    entry_t            pkt;
    entry_t            shown;
    logic              out_valid_reg;
    logic              pop_ok_reg;
    logic              more_reg;
    logic              out_free;
    logic              is_rd;
    logic              is_byte;
    logic              empty;
    logic              rd_en;
    logic              pkt_done;
    logic              mem_we;
    logic              four_byte;

    assign out_free  = !out_valid_reg || m_tready;
    assign q_pop     = q_valid && ((q_item.cmd == CMD_BYTE) || out_free);
    assign is_rd     = q_pop && (q_item.cmd == CMD_READ);
    assign is_byte   = q_pop && (q_item.cmd == CMD_BYTE);
    assign empty     = (rd_idx_reg == wr_idx_reg);
    assign rd_en     = is_rd && !empty;
    assign four_byte = (packet_mode == MODE_WHEEL) || (packet_mode == MODE_BTN5);

    // Byte assembly; a header without the sync bit is dropped to realign.
    always_comb
    begin
        phase_next = phase_reg;
        hdr_next   = hdr_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        pkt_done   = 1'b0;
        pkt        = decode_packet(hdr_reg, x_reg, q_item.data, 8'd0, packet_mode);
        if (is_byte)
        begin
            case (phase_reg)
                PH_HDR:
                begin
                    hdr_next = q_item.data;
                    if (q_item.data[HDR_SYNC])
                    begin
                        phase_next = PH_X;
                    end
                end
                PH_X:
                begin
                    x_next     = q_item.data;
                    phase_next = PH_Y;
                end
                PH_Y:
                begin
                    y_next = q_item.data;
                    if (four_byte)
                    begin
                        phase_next = PH_W;
                    end
                    else
                    begin
                        phase_next = PH_HDR;
                        pkt_done   = 1'b1;
                    end
                end
                PH_W:
                begin
                    phase_next = PH_HDR;
                    pkt_done   = 1'b1;
                    pkt = decode_packet(hdr_reg, x_reg, y_reg, q_item.data, packet_mode);
                end
                default:
                begin
                    phase_next = PH_HDR;
                end
            endcase
        end
    end

    // One slot stays empty, so a full buffer drops the new packet.
    assign mem_we = pkt_done && (buf_inc(wr_idx_reg) != rd_idx_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HDR;
            hdr_reg       <= '0;
            x_reg         <= '0;
            y_reg         <= '0;
            wr_idx_reg    <= '0;
            rd_idx_reg    <= '0;
            out_valid_reg <= 1'b0;
            pop_ok_reg    <= 1'b0;
            more_reg      <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            hdr_reg   <= hdr_next;
            x_reg     <= x_next;
            y_reg     <= y_next;
            if (mem_we)
            begin
                wr_idx_reg <= buf_inc(wr_idx_reg);
            end
            if (rd_en)
            begin
                rd_idx_reg <= buf_inc(rd_idx_reg);
            end
            if (is_rd)
            begin
                out_valid_reg <= 1'b1;
                pop_ok_reg    <= !empty;
                more_reg      <= !empty && (buf_inc(rd_idx_reg) != wr_idx_reg);
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_idx_reg] <= pkt;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_idx_reg];
        end
    end

    // An empty read reports all fields as zero.
    assign shown    = pop_ok_reg ? rd_data_reg : '0;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, more_reg, shown.scroll_down, shown.scroll_up, shown.middle,
                       shown.right, shown.left, shown.dy, shown.dx, pop_ok_reg};

    `CHECK_NEXT(a_read_gives_result, is_rd, out_valid_reg, "read item left no result")
    `CHECK_IMPLIES(a_rd_idx_on_pop, rd_idx_reg != $past(rd_idx_reg), $past(rd_en),
                   "read index moved without a pop")
    `CHECK_IMPLIES(a_empty_no_more, out_valid_reg && !pop_ok_reg, !more_reg,
                   "empty read reports more pending")
    `CHECK_NEXT(a_packet_end, pkt_done, phase_reg == PH_HDR,
                "byte phase did not return to header after a packet")

endmodule

FILE: tb/ps2_mouse_packet_decoder_fifo_top_tb.sv
// Self-checking testbench for the PS/2 mouse packet decoder with packet buffer.
// Drives byte and read items, predicts every read result and checks it field by field.
// Depends on ps2mf_pkg and ps2_mouse_packet_decoder_fifo_top.
`timescale 1ns / 100ps

module ps2_mouse_packet_decoder_fifo_top_tb;
    import ps2mf_pkg::*;

    localparam real CLK_PERIOD     = 12.0;
    localparam int  RESET_CYCLES   = 12;
    localparam int  WATCHDOG_LIMIT = 1000;
    localparam int  DRAIN_CYCLES   = 8;
    localparam int  RANDOM_ITEMS   = 2000;
    localparam int  CALM_ITEMS     = 200;
    localparam int  FILL_PACKETS   = 18;

    localparam logic [2:0] ADDR_MODE  = {REG_PACKET_MODE, 2'b00};
    localparam logic [2:0] ADDR_SPARE = {~REG_PACKET_MODE, 2'b00};

    // Read result as it sits in m_tdata[24:0], packet_valid in the lowest bit.
    typedef struct packed {
        logic       more;
        logic       scroll_down;
        logic       scroll_up;
        logic       middle;
        logic       right;
        logic       left;
        logic [8:0] dy;
        logic [8:0] dx;
        logic       valid;
    } read_result_t;

    typedef enum {
        ROW_BYTE,
        ROW_READ,
        ROW_MODE
    } row_kind_t;

    typedef struct {
        row_kind_t    kind;
        logic [7:0]   val;
        bit           typed;
        read_result_t exp;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] rx_byte
    logic        s_tuser;   // [0] cmd
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // [0] valid, [9:1] dx, [18:10] dy, [24:19] buttons, scroll, more
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Predictor state.
    mode_t        cur_mode;
    logic [1:0]   phase_q;
    logic [7:0]   hdr_q;
    logic [7:0]   x_q;
    logic [7:0]   y_q;
    read_result_t pkt_ring [BUF_DEPTH];
    logic [3:0]   ring_wr;
    logic [3:0]   ring_rd;

    read_result_t expected_reads [$];
    stim_row_t    dir_rows [$];
    int           errors;
    int           items_sent;
    int           idle_cycles;
    int           stall_left;
    bit           calm;

    ps2_mouse_packet_decoder_fifo_top u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #(CLK_PERIOD / 2.0) clk = ~clk;

    // Builds the stored packet from the three collected bytes and the wheel byte.
    function automatic read_result_t decode_mouse_packet(input logic [7:0] wheel);
        read_result_t r;
        r = '0;
        r.valid = 1'b1;
        r.dx = {(x_q != 8'd0) && hdr_q[HDR_XSIGN], x_q};
        r.dy = {(y_q != 8'd0) && hdr_q[HDR_YSIGN], y_q};
        if (hdr_q[HDR_XOVF] || hdr_q[HDR_YOVF])
        begin
            r.dx = '0;
            r.dy = '0;
        end
        r.left   = hdr_q[HDR_LEFT];
        r.right  = hdr_q[HDR_RIGHT];
        r.middle = hdr_q[HDR_MIDDLE];
        if (cur_mode == MODE_WHEEL && wheel != 8'd0)
        begin
            r.scroll_up   = wheel[7];
            r.scroll_down = !wheel[7];
        end
        return r;
    endfunction

    function automatic void store_packet(input read_result_t r);
        // One slot always stays empty, so a full ring drops the packet.
        if (ring_wr + 4'd1 != ring_rd)
        begin
            pkt_ring[ring_wr] = r;
            ring_wr = ring_wr + 4'd1;
        end
    endfunction

    // Advances the decoder by one item; returns 1 when the item yields a read result.
    function automatic bit advance_decoder(input cmd_t cmd, input logic [7:0] b,
                                           output read_result_t res);
        res = '0;
        if (cmd == CMD_READ)
        begin
            if (ring_rd != ring_wr)
            begin
                res = pkt_ring[ring_rd];
                ring_rd = ring_rd + 4'd1;
                res.more = (ring_rd != ring_wr);
            end
            return 1'b1;
        end
        case (phase_q)
            2'd0:
            begin
                hdr_q = b;
                if (b[HDR_SYNC])
                begin
                    phase_q = 2'd1;
                end
            end
            2'd1:
            begin
                x_q = b;
                phase_q = 2'd2;
            end
            2'd2:
            begin
                y_q = b;
                if (cur_mode == MODE_WHEEL || cur_mode == MODE_BTN5)
                begin
                    phase_q = 2'd3;
                end
                else
                begin
                    phase_q = 2'd0;
                    store_packet(decode_mouse_packet(8'd0));
                end
            end
            default:
            begin
                phase_q = 2'd0;
                store_packet(decode_mouse_packet(b));
            end
        endcase
        return 1'b0;
    endfunction

    task automatic check_field(input string name, input logic [8:0] exp, input logic [8:0] act);
        if (exp !== act)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp, act);
            errors++;
        end
    endtask

    task automatic check_read(input logic [31:0] data);
        read_result_t exp;
        read_result_t act;
        act = read_result_t'(data[24:0]);
        if (expected_reads.size() == 0)
        begin
            $display("%0t: unexpected result, expected none, actual %h", $time, data);
            errors++;
        end
        else
        begin
            exp = expected_reads.pop_front();
            check_field("packet_valid", 9'(exp.valid), 9'(act.valid));
            check_field("delta_x", exp.dx, act.dx);
            check_field("delta_y", exp.dy, act.dy);
            check_field("left_button", 9'(exp.left), 9'(act.left));
            check_field("right_button", 9'(exp.right), 9'(act.right));
            check_field("middle_button", 9'(exp.middle), 9'(act.middle));
            check_field("scroll_up", 9'(exp.scroll_up), 9'(act.scroll_up));
            check_field("scroll_down", 9'(exp.scroll_down), 9'(act.scroll_down));
            check_field("more_pending", 9'(exp.more), 9'(act.more));
        end
    endtask

    // Sends one item, optionally after a short gap, and predicts its result on acceptance.
    task automatic send_item(input cmd_t cmd, input logic [7:0] b,
                             input bit typed, input read_result_t typed_exp);
        read_result_t res;
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= b;
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        items_sent++;
        if (advance_decoder(cmd, b, res))
        begin
            expected_reads.push_back(typed ? typed_exp : res);
        end
    endtask

    task automatic send_read();
        send_item(CMD_READ, 8'($urandom_range(0, 255)), 1'b0, '0);
    endtask

    // A well-formed packet with random content, sized for the current mode.
    task automatic send_packet();
        logic [7:0] hdr;
        int         n;
        hdr = 8'($urandom_range(0, 255)) | (8'd1 << HDR_SYNC);
        if ($urandom_range(0, 7) != 0)
        begin
            hdr[HDR_YOVF] = 1'b0;
            hdr[HDR_XOVF] = 1'b0;
        end
        n = (cur_mode == MODE_WHEEL || cur_mode == MODE_BTN5) ? 4 : 3;
        send_item(CMD_BYTE, hdr, 1'b0, '0);
        for (int i = 1; i < n; i++)
        begin
            send_item(CMD_BYTE, ($urandom_range(0, 5) == 0) ? 8'd0 : 8'($urandom_range(0, 255)),
                      1'b0, '0);
        end
    endtask

    // Waits until every expected result is in and the pipeline has emptied.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_reads.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (addr == ADDR_MODE)
        begin
            cur_mode = mode_t'(value[1:0]);
        end
        // The bus idles before returning so that a following write starts at a later edge.
        @(posedge clk);
    endtask

    // Output side: accepts results and stalls in short random bursts.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                check_read(m_tdata);
            end
            if (stall_left > 0)
            begin
                stall_left--;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 4);
            end
            m_tready <= (stall_left == 0);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
                if (idle_cycles >= WATCHDOG_LIMIT)
                begin
                    $display("%0t: no item accepted for %0d cycles", $time, idle_cycles);
                    $display("FAIL");
                    $finish;
                end
            end
        end
    end

    initial
    begin
        int last_item;
        read_result_t zero_sign;
        read_result_t overflow_last;

        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= 8'd0;
        s_tuser  <= CMD_BYTE;
        m_tready <= 1'b1;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        errors      = 0;
        items_sent  = 0;
        idle_cycles = 0;
        stall_left  = 0;
        calm        = 1'b0;
        cur_mode    = MODE_STD;
        phase_q     = 2'd0;
        hdr_q       = 8'd0;
        x_q         = 8'd0;
        y_q         = 8'd0;
        ring_wr     = 4'd0;
        ring_rd     = 4'd0;

        zero_sign = '0;
        zero_sign.valid  = 1'b1;
        zero_sign.left   = 1'b1;
        zero_sign.right  = 1'b1;
        zero_sign.middle = 1'b1;
        overflow_last = '0;
        overflow_last.valid = 1'b1;

        // Read on an empty buffer, a dropped unsynced header, zero deltas with sign
        // bits, the delta extremes, overflow, then wheel packets in both directions.
        dir_rows.push_back('{ROW_READ, 8'hFF, 1'b1, '0});
        dir_rows.push_back('{ROW_BYTE, 8'h00, 1'b0, '0});
        dir_rows.push_back('{ROW_BYTE, 8'h3F, 1'b0, '0});
        dir_rows.push_back('{ROW_BYTE, 8'h00, 1'b0, '0});
        dir_rows.push_back('{ROW_BYTE, 8'h00, 1'b0, '0});
        dir_rows.push_back('{ROW_READ, 8'h00, 1'b1, zero_sign});
        dir_rows.push_back('{ROW_BYTE, 8'h18, 1'b0, '0});
        dir_rows.push_back('{ROW_BYTE, 8'h01, 1'b0, '0});
        dir_rows.push_back('{ROW_BYTE, 8'hFF, 1'b0, '0});
        dir_rows.push_back('{ROW_BYTE, 8'hC8, 1'b0, '0});
        dir_rows.push_back('{ROW_BYTE, 8'h55, 1'b0, '0});
        dir_rows.push_back('{ROW_BYTE, 8'hAA, 1'b0, '0});
        dir_rows.push_back('{ROW_READ, 8'h00, 1'b0, '0});
        dir_rows.push_back('{ROW_READ, 8'h00, 1'b1, overflow_last});
        dir_rows.push_back('{ROW_MODE, 8'(MODE_WHEEL), 1'b0, '0});
        dir_rows.push_back('{ROW_BYTE, 8'h29, 1'b0, '0});
        dir_rows.push_back('{ROW_BYTE, 8'hFF, 1'b0, '0});
        dir_rows.push_back('{ROW_BYTE, 8'h80, 1'b0, '0});
        dir_rows.push_back('{ROW_BYTE, 8'hFF, 1'b0, '0});
        dir_rows.push_back('{ROW_BYTE, 8'h0A, 1'b0, '0});
        dir_rows.push_back('{ROW_BYTE, 8'h7F, 1'b0, '0});
        dir_rows.push_back('{ROW_BYTE, 8'h01, 1'b0, '0});
        dir_rows.push_back('{ROW_BYTE, 8'h01, 1'b0, '0});
        dir_rows.push_back('{ROW_READ, 8'h00, 1'b0, '0});
        dir_rows.push_back('{ROW_READ, 8'h00, 1'b0, '0});

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            case (dir_rows[i].kind)
                ROW_BYTE: send_item(CMD_BYTE, dir_rows[i].val, dir_rows[i].typed, dir_rows[i].exp);
                ROW_READ: send_item(CMD_READ, dir_rows[i].val, dir_rows[i].typed, dir_rows[i].exp);
                default:
                begin
                    wait_drained();
                    write_reg(ADDR_MODE, 32'(dir_rows[i].val));
                end
            endcase
        end

        // Random phases, each under its own mode; some fill the buffer past full.
        last_item = items_sent + RANDOM_ITEMS;
        while (items_sent < last_item)
        begin
            wait_drained();
            if ($urandom_range(0, 7) == 0)
            begin
                write_reg(ADDR_SPARE, $urandom);
            end
            write_reg(ADDR_MODE, 32'($urandom_range(0, 3)));
            if ($urandom_range(0, 3) == 0)
            begin
                repeat (FILL_PACKETS) send_packet();
                repeat (FILL_PACKETS) send_read();
            end
            else
            begin
                repeat ($urandom_range(30, 120))
                begin
                    calm = (items_sent >= last_item - CALM_ITEMS);
                    case ($urandom_range(0, 9))
                        0:          send_item(CMD_BYTE, 8'($urandom_range(0, 255)), 1'b0, '0);
                        1, 2, 3:    send_read();
                        default:    send_packet();
                    endcase
                end
            end
            calm = (items_sent >= last_item - CALM_ITEMS);
        end

        wait_drained();
        if (errors == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/ps2mf_pkg.sv
hw/rtl/ps2mf_front.sv
hw/rtl/ps2mf_queue.sv
hw/rtl/ps2mf_back.sv
hw/rtl/ps2_mouse_packet_decoder_fifo_top.sv
tb/ps2_mouse_packet_decoder_fifo_top_tb.sv
